// File: rtl/appl_pkg.sv
// Shared types and constants of the adaptive page prefetch list core.
// No dependencies; imported by the core and by the residency map.
package appl_pkg;

   localparam int PAGE_W           = 12;
   localparam int BIT_W            = 5;
   localparam int WORD_W           = 32;
   localparam int ROW_W            = PAGE_W - BIT_W;
   localparam int ROWS             = 1 << ROW_W;
   localparam int REGION_W         = 13;
   localparam int BATCH_W          = 5;
   localparam int RUN_W            = 3;
   localparam int WIN_W            = 6;

   localparam int REGION_PAGES_MAX = 4096;
   localparam int BATCH_MAX        = 16;
   localparam int INITIAL_WINDOW   = 4;
   localparam int WINDOW_CAP       = 32;
   localparam int RUN_THRESHOLD    = 4;
   localparam int RUN_SAT          = 5;

   localparam logic ACT_FAULT = 1'b0;
   localparam logic ACT_SET   = 1'b1;

   localparam logic CSR_REGION_PAGES = 1'b0;
   localparam logic CSR_BATCH_LIMIT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_READ,
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH
   } appl_state_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ROW_W-1:0]  row;
      logic [WORD_W-1:0] wdata;
   } appl_mem_req_type;

endpackage

// File: rtl/appl_resmap.sv
// Residency bitmap: one synchronous word memory with a registered read and
// a valid bit per row so that reset clears the map at once. Uses appl_pkg.
module appl_resmap (
   input  logic                         clock,
   input  logic                         reset,
   input  appl_pkg::appl_mem_req_type   mem_req,
   output logic [appl_pkg::WORD_W-1:0]  rd_word
);
   import appl_pkg::*;

   logic [WORD_W-1:0] mem [ROWS];
   logic [ROWS-1:0]   valid_ff;
   logic [WORD_W-1:0] rdata_ff;
   logic              rvalid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.row] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.row] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rvalid_ff <= valid_ff[mem_req.row];
         end
      end
   end

   // a row never written reads as nothing resident
   assign rd_word = rvalid_ff ? rdata_ff : '0;

endmodule

// File: rtl/adaptive_page_prefetch_list_core.sv
// Adaptive page prefetch list core: answers page faults with a fetch list
// and keeps the residency bitmap. Depends on appl_pkg and appl_resmap.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_tvalid/tready   | tuser = action, tdata = page, resident
//   rsp     | out       | rsp_tvalid/tready   | tdata = fetch index, tlast = last
//   csr     | in        | csr_wen             | csr_index, csr_wdata
//
// One word at a time. A residency update steps through accept, read row and write row.
// A fault is accepted, then each 32-page bitmap row it scans is read, loaded and advanced
// (the row that fills the batch or ends the region has no advance), each page the scan
// adds is emitted and the last word flushed; the single memory port sets this. Reset is
// synchronous and clears the map at once through row valid bits. A stalled rsp side holds
// the scan; req is taken again once the last word of a list sits in the output register.
module adaptive_page_prefetch_list_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [11:0] page_index, [12] resident
   input  logic                           req_tuser,   // [0] action
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [11:0] fetch_index
   output logic                           rsp_tlast,
   input  logic                           csr_wen,
   input  logic                           csr_index,
   input  logic [appl_pkg::REGION_W-1:0]  csr_wdata
);
   import appl_pkg::*;

   appl_state_type      state_ff, state_in;

   // prefetch history
   logic [PAGE_W-1:0]   prev_ff, prev_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [WIN_W-1:0]    win_ff, win_in;

   // configuration
   logic [REGION_W-1:0] region_ff;
   logic [BATCH_W-1:0]  batch_ff;

   // per item working state
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic                res_ff, res_in;
   logic [PAGE_W-1:0]   start_ff, start_in;
   logic [REGION_W-1:0] end_ff, end_in;
   logic [BATCH_W-1:0]  limit_ff, limit_in;
   logic [BATCH_W-1:0]  count_ff, count_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [WORD_W-1:0]   mask_ff, mask_in;
   logic [PAGE_W-1:0]   held_ff, held_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                rsp_last_ff, rsp_last_in;

   appl_mem_req_type    mem_req;
   logic [WORD_W-1:0]   rd_word;

   logic                req_fire;
   logic                out_free;
   logic [PAGE_W-1:0]   req_page;
   logic                seq_fault;
   logic [RUN_W-1:0]    run_next;
   logic [WIN_W-1:0]    win_next;
   logic [WIN_W:0]      win_dbl;
   logic [PAGE_W-1:0]   start_next;
   logic [REGION_W-1:0] end_next;
   logic [BATCH_W-1:0]  limit_next;
   logic [WORD_W-1:0]   fresh_mask;
   logic [WORD_W-1:0]   merged_word;
   logic [BIT_W-1:0]    low_bit;
   logic [ROW_W:0]      row_inc;
   logic                row_past_end;
   logic [BATCH_W-1:0]  count_inc;

   appl_resmap u_resmap (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_page   = req_tdata[PAGE_W-1:0];
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - PAGE_W){1'b0}}, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

   // window and run update for the fault on the req bus
   always_comb begin
      seq_fault = ({1'b0, req_page} == ({1'b0, prev_ff} + 13'd1));
      run_next  = run_ff;
      win_next  = win_ff;
      win_dbl   = {win_ff, 1'b0};
      if (seq_fault) begin
         if (run_ff < RUN_W'(RUN_SAT)) begin
            run_next = run_ff + 3'd1;
         end
         if ((run_next > RUN_W'(RUN_THRESHOLD)) && (win_ff < WIN_W'(WINDOW_CAP))) begin
            win_next = (win_dbl > 7'(WINDOW_CAP)) ? WIN_W'(WINDOW_CAP) : win_dbl[WIN_W-1:0];
         end
      end else if (req_page != prev_ff) begin
         run_next = '0;
         win_next = (win_ff > 6'd1) ? (win_ff >> 1) : 6'd1;
      end
      start_next = (req_page > {{(PAGE_W - WIN_W){1'b0}}, win_next})
                 ? (req_page - {{(PAGE_W - WIN_W){1'b0}}, win_next}) : '0;
      end_next   = (region_ff > REGION_W'(REGION_PAGES_MAX))
                 ? REGION_W'(REGION_PAGES_MAX) : region_ff;
      limit_next = (batch_ff > BATCH_W'(BATCH_MAX)) ? BATCH_W'(BATCH_MAX) : batch_ff;
   end

   // candidates of the freshly read row: not resident, inside [start, end),
   // and not the fault page itself
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         fresh_mask[b] = ~rd_word[b];
         if ((row_ff == start_ff[PAGE_W-1:BIT_W]) && (BIT_W'(b) < start_ff[BIT_W-1:0])) begin
            fresh_mask[b] = 1'b0;
         end
         if (({1'b0, row_ff} == end_ff[REGION_W-1:BIT_W]) &&
             (BIT_W'(b) >= end_ff[BIT_W-1:0])) begin
            fresh_mask[b] = 1'b0;
         end
         if ((row_ff == page_ff[PAGE_W-1:BIT_W]) && (BIT_W'(b) == page_ff[BIT_W-1:0])) begin
            fresh_mask[b] = 1'b0;
         end
      end
   end

   // merge the residency bit into the row just read
   always_comb begin
      merged_word = rd_word;
      merged_word[page_ff[BIT_W-1:0]] = res_ff;
   end

   // lowest remaining candidate
   always_comb begin
      low_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (mask_ff[b]) begin
            low_bit = BIT_W'(b);
         end
      end
   end

   assign row_inc      = {1'b0, row_ff} + 8'd1;
   assign row_past_end = ({row_inc, {BIT_W{1'b0}}} >= end_ff);
   assign count_inc    = count_ff + 5'd1;

   assign mem_req.rd_en = (state_ff == ST_READ) || (state_ff == ST_UPD_RD);
   assign mem_req.wr_en = (state_ff == ST_UPD_WR);
   assign mem_req.row   = row_ff;
   assign mem_req.wdata = merged_word;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ACT_SET) begin
                  state_in = ST_UPD_RD;
               end else if ((limit_next <= 5'd1) || ({1'b0, start_next} >= end_next)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: state_in = ST_IDLE;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (mask_ff != '0) begin
               if (out_free && (count_inc == limit_ff)) begin
                  state_in = ST_FLUSH;
               end
            end else if (row_past_end) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output register
   always_comb begin
      prev_in      = prev_ff;
      run_in       = run_ff;
      win_in       = win_ff;
      page_in      = page_ff;
      res_in       = res_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      mask_in      = mask_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               page_in = req_page;
               res_in  = req_tdata[PAGE_W];
               row_in  = req_page[PAGE_W-1:BIT_W];
               if (req_tuser == ACT_FAULT) begin
                  prev_in  = req_page;
                  run_in   = run_next;
                  win_in   = win_next;
                  start_in = start_next;
                  end_in   = end_next;
                  limit_in = limit_next;
                  count_in = 5'd1;
                  held_in  = req_page;
                  row_in   = start_next[PAGE_W-1:BIT_W];
               end
            end
         end
         ST_LOAD: begin
            mask_in = fresh_mask;
         end
         ST_SCAN: begin
            if (mask_ff != '0) begin
               // emit the held page, hold the new candidate
               if (out_free) begin
                  rsp_valid_in     = 1'b1;
                  rsp_index_in     = held_ff;
                  rsp_last_in      = 1'b0;
                  held_in          = {row_ff, low_bit};
                  mask_in[low_bit] = 1'b0;
                  count_in         = count_inc;
               end
            end else if (!row_past_end) begin
               row_in = row_inc[ROW_W-1:0];
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = held_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         run_ff       <= '0;
         win_ff       <= WIN_W'(INITIAL_WINDOW);
         region_ff    <= REGION_W'(REGION_PAGES_MAX);
         batch_ff     <= BATCH_W'(BATCH_MAX);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         run_ff       <= run_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_REGION_PAGES: region_ff <= csr_wdata;
               CSR_BATCH_LIMIT:  batch_ff  <= csr_wdata[BATCH_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      res_ff       <= res_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      limit_ff     <= limit_in;
      count_ff     <= count_in;
      row_ff       <= row_in;
      mask_ff      <= mask_in;
      held_ff      <= held_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// File: rtl/appl_checker.sv
// Port level checks of the adaptive page prefetch list core, and the bind
// that attaches them. Depends only on the core's port list.
module appl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

   // the core is busy right after it accepts a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted in back to back cycles");

   // page indices fit in twelve bits
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:12] == 4'd0))
      else $error("fetch index padding not zero");

endmodule

bind adaptive_page_prefetch_list_core appl_checker u_appl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: test/testbench.sv
// Self-checking bench for adaptive_page_prefetch_list_core: directed table, then random
// fault runs and residency words, all checked against an in-bench prefetch list predictor.
// Depends on appl_pkg and the core RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import appl_pkg::*;

   typedef struct packed {
      logic [PAGE_W-1:0] index;
      logic              last;
   } fetch_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // One line of the directed table: either a request word or a register write.
   // A row marked typed carries its single expected fetch index, listed as last.
   typedef struct packed {
      row_kind_type      kind;
      logic              action;
      logic [PAGE_W-1:0] page;
      logic              resident;
      logic              csr_sel;
      logic [REGION_W-1:0] value;
      logic              typed;
      logic [PAGE_W-1:0] typed_page;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // [11:0] page_index, [12] resident
   logic                req_tuser = 1'b0; // [0] action
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;        // [11:0] fetch_index
   logic                rsp_tlast;
   logic                csr_wen = 1'b0;
   logic                csr_index = 1'b0;
   logic [REGION_W-1:0] csr_wdata = '0;

   // Predictor state, a private copy of what the core holds.
   bit                  resident_map [REGION_PAGES_MAX];
   logic [PAGE_W-1:0]   last_fault;
   int unsigned         run_len;
   int unsigned         window;
   logic [REGION_W-1:0] cfg_region;
   logic [BATCH_W-1:0]  cfg_batch;

   fetch_type           fetch_list[$];      // list worked out for the latest fault
   fetch_type           pending_fetches[$]; // words still owed by the core
   stim_row_type        directed_rows[$];

   int                  send_idle_pct;
   int                  rsp_stall_pct;
   int                  error_count;
   int                  faults_sent;
   int                  updates_sent;
   int                  results_checked;

   adaptive_page_prefetch_list_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Hard stop in case the core hangs.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // Advance the window and run count for one fault, then build its fetch list:
   // fault page first, then the upward scan over non-resident pages.
   function automatic void predict_fetch_list(input logic [PAGE_W-1:0] page);
      int unsigned       pg;
      int unsigned       prev;
      int unsigned       lim;
      int unsigned       stop;
      int unsigned       p;
      logic [PAGE_W-1:0] picks[$];
      pg   = page;
      prev = last_fault;
      if (pg == prev + 1) begin
         if (run_len < RUN_SAT) run_len++;
         if (run_len > RUN_THRESHOLD && window < WINDOW_CAP) begin
            window = window * 2;
            if (window > WINDOW_CAP) window = WINDOW_CAP;
         end
      end else if (pg != prev) begin
         // any jump other than a repeat ends the run
         run_len = 0;
         window  = window / 2;
         if (window < 1) window = 1;
      end
      last_fault = page;

      lim  = (cfg_batch > BATCH_MAX) ? BATCH_MAX : cfg_batch;
      stop = cfg_region;
      if (stop > REGION_PAGES_MAX) stop = REGION_PAGES_MAX;
      if (stop > (1 << PAGE_W)) stop = 1 << PAGE_W;

      picks.push_back(page);
      // a zero batch limit still lets the fault page through
      for (p = (pg > window) ? pg - window : 0; p < stop && picks.size() < lim; p++) begin
         if (p != pg && !resident_map[p]) picks.push_back(p[PAGE_W-1:0]);
      end
      fetch_list.delete();
      foreach (picks[i]) fetch_list.push_back('{picks[i], i == picks.size() - 1});
   endfunction

   // Hold the word until taken, then book its expectations; maybe idle afterwards.
   task automatic send_word(input logic act, input logic [PAGE_W-1:0] page,
                            input logic res, input logic typed,
                            input logic [PAGE_W-1:0] typed_page);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, res, page};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACT_SET) begin
         resident_map[page] = res;
         updates_sent++;
      end else begin
         predict_fetch_list(page);
         if (typed) pending_fetches.push_back('{typed_page, 1'b1});
         else foreach (fetch_list[i]) pending_fetches.push_back(fetch_list[i]);
         faults_sent++;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // Drop valid, drain every owed word, then let an update in flight settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_fetches.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Pulse the write enable for one edge and update the predictor's copy of the register.
   task automatic write_reg(input logic sel, input logic [REGION_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      if (sel == CSR_REGION_PAGES) cfg_region = value;
      else cfg_batch = value[BATCH_W-1:0];
      @(posedge clock);
   endtask

   function automatic void word_row(input logic act, input logic [PAGE_W-1:0] page,
                                    input logic res, input logic typed,
                                    input logic [PAGE_W-1:0] typed_page);
      directed_rows.push_back('{ROW_WORD, act, page, res, 1'b0, '0, typed, typed_page});
   endfunction

   function automatic void csr_row(input logic sel, input logic [REGION_W-1:0] value);
      directed_rows.push_back('{ROW_CSR, ACT_FAULT, '0, 1'b0, sel, value, 1'b0, '0});
   endfunction

   // Randomly stall the result side at the current phase's rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check each accepted result word against the oldest owed one.
   always @(posedge clock) begin : result_check
      fetch_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fetches.size() == 0) begin
            report_mismatch($sformatf("unexpected word, index %0d last %0b",
                                      rsp_tdata[PAGE_W-1:0], rsp_tlast));
         end else begin
            want = pending_fetches.pop_front();
            results_checked++;
            if (rsp_tdata !== {{(16-PAGE_W){1'b0}}, want.index})
               report_mismatch($sformatf("fetch_index got %0d want %0d",
                                         rsp_tdata, want.index));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last got %0b want %0b at index %0d",
                                         rsp_tlast, want.last, want.index));
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          n;
      int          run_left;
      int          r;
      logic [PAGE_W-1:0] hot_base;
      logic [PAGE_W-1:0] pg;

      foreach (resident_map[i]) resident_map[i] = 1'b0;
      last_fault    = '0;
      run_len       = 0;
      window        = INITIAL_WINDOW;
      cfg_region    = REGION_PAGES_MAX;
      cfg_batch     = BATCH_MAX;
      error_count   = 0;
      faults_sent   = 0;
      updates_sent  = 0;
      results_checked = 0;
      send_idle_pct = 17;
      rsp_stall_pct = 58;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: top and bottom pages, repeat faults, a run long enough
      // to saturate the count and cap the window, zero and oversized registers.
      word_row(ACT_FAULT, 12'd0,    1'b1, 1'b0, '0);
      word_row(ACT_FAULT, 12'd4095, 1'b0, 1'b0, '0);
      word_row(ACT_SET,   12'd4094, 1'b1, 1'b0, '0);
      word_row(ACT_SET,   12'd4093, 1'b1, 1'b0, '0);
      word_row(ACT_FAULT, 12'd4095, 1'b0, 1'b1, 12'd4095); // repeat, neighbors resident
      word_row(ACT_SET,   12'd4093, 1'b0, 1'b0, '0);
      word_row(ACT_FAULT, 12'd0,    1'b0, 1'b0, '0);       // no wrap after the top page
      for (int p = 1; p <= 10; p++) word_row(ACT_FAULT, p[PAGE_W-1:0], 1'b0, 1'b0, '0);
      csr_row(CSR_BATCH_LIMIT, 13'd0);
      word_row(ACT_FAULT, 12'd200,  1'b0, 1'b1, 12'd200);
      csr_row(CSR_BATCH_LIMIT, 13'd31);
      word_row(ACT_FAULT, 12'd300,  1'b0, 1'b0, '0);
      csr_row(CSR_REGION_PAGES, 13'd0);
      word_row(ACT_FAULT, 12'd5,    1'b0, 1'b1, 12'd5);
      csr_row(CSR_REGION_PAGES, 13'd8191);
      word_row(ACT_FAULT, 12'd4090, 1'b0, 1'b0, '0);
      csr_row(CSR_REGION_PAGES, 13'd8);
      word_row(ACT_FAULT, 12'd4095, 1'b0, 1'b1, 12'd4095); // outside the region
      csr_row(CSR_BATCH_LIMIT, 13'd1);
      word_row(ACT_FAULT, 12'd3,    1'b0, 1'b1, 12'd3);
      csr_row(CSR_REGION_PAGES, 13'd4096);
      csr_row(CSR_BATCH_LIMIT, 13'd16);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_reg(directed_rows[i].csr_sel, directed_rows[i].value);
         end else begin
            send_word(directed_rows[i].action, directed_rows[i].page,
                      directed_rows[i].resident, directed_rows[i].typed,
                      directed_rows[i].typed_page);
         end
      end

      // Random part in three phases: sender light / receiver heavy idling, then
      // swapped, then none. Each phase starts from a fresh register setting.
      for (phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 17;
               rsp_stall_pct = 58;
               write_reg(CSR_REGION_PAGES, 13'd4096);
               write_reg(CSR_BATCH_LIMIT, 13'd16);
            end
            1: begin
               send_idle_pct = 58;
               rsp_stall_pct = 17;
               write_reg(CSR_REGION_PAGES, REGION_W'($urandom_range(64, 4095)));
               write_reg(CSR_BATCH_LIMIT, REGION_W'($urandom_range(2, 15)));
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               write_reg(CSR_REGION_PAGES, REGION_W'($urandom_range(4097, 8191)));
               write_reg(CSR_BATCH_LIMIT, REGION_W'($urandom_range(17, 31)));
            end
         endcase
         // keep most traffic in a small hot area so residency shapes the scans
         hot_base = PAGE_W'($urandom_range(0, 4095 - 64));
         if (phase == 1 && hot_base + 64 > cfg_region) hot_base = PAGE_W'(cfg_region - 64);
         run_left = 0;
         for (n = 0; n < 86; n++) begin
            r = $urandom_range(99);
            if (run_left > 0 && r >= 25) begin
               // continue the sequential run
               send_word(ACT_FAULT, last_fault + 1'b1, 1'($urandom_range(1)), 1'b0, '0);
               run_left--;
            end else if (run_left > 0 || r < 30) begin
               pg = ($urandom_range(99) < 80) ? PAGE_W'(hot_base + $urandom_range(63))
                                              : PAGE_W'($urandom_range(4095));
               send_word(ACT_SET, pg, 1'($urandom_range(1)), 1'b0, '0);
            end else if (r < 60) begin
               // open a new run somewhere in the hot area
               send_word(ACT_FAULT, PAGE_W'(hot_base + $urandom_range(63)),
                         1'($urandom_range(1)), 1'b0, '0);
               run_left = $urandom_range(3, 9);
            end else if (r < 70) begin
               send_word(ACT_FAULT, last_fault, 1'($urandom_range(1)), 1'b0, '0);
            end else if (r < 85) begin
               send_word(ACT_FAULT, PAGE_W'($urandom_range(4095)), 1'($urandom_range(1)),
                         1'b0, '0);
            end else begin
               send_word(ACT_FAULT, PAGE_W'(hot_base + $urandom_range(63)),
                         1'($urandom_range(1)), 1'b0, '0);
            end
         end
      end

      // Drain, then give a stray late word time to show up.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_fetches.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d faults and %0d residency words, %0d fetch words checked,",
               faults_sent, updates_sent, results_checked);
      $display("over three idling mixes and region/batch settings from zero to full scale.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
